// ===== design/lrmt_pkg.sv =====
// Shared definitions for the lazy range-add / range-minimum tree.
// Holds the operation codes, the empty-range value and the command and status bundles.
// Used by lrmt_ctl, lrmt_dp and lazy_range_add_min_tree_core.
package lrmt_pkg;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_ADD = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [31:0] TOP_VALUE = 32'h7FFF_FFFF;
	localparam logic [10:0] LENGTH_RESET = 11'd1024;

	typedef struct packed {
		logic accept;
		logic clr;
		logic rd_node;
		logic visit;
		logic ch1;
		logic ch2;
		logic next;
		logic go_right;
		logic ret_min;
		logic rf1;
		logic rf2;
		logic rf3;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic bad;
		logic ch_push;
		logic next_ret;
		logic empty;
		logic top_right;
		logic full;
		logic [1:0] op;
		logic out_free;
	} st_t;

endpackage

// ===== design/lrmt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module lrmt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/lrmt_dp.sv =====
// Datapath of the tree: node and pending stores, the traversal stack, the length register
// and the result register. Driven by the command bundle from lrmt_ctl.
// Depends on lrmt_pkg and lrmt_ram.
module lrmt_dp #(
	parameter int MAX_LENGTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lrmt_pkg::cmd_t      cmd,
	output lrmt_pkg::st_t       st,
	input  logic                cfg_valid,
	input  logic [10:0]         cfg_data,
	input  logic [1:0]          op,
	input  logic [9:0]          range_low,
	input  logic [9:0]          range_high,
	input  logic signed [31:0]  operand_value,
	output logic                result_valid,
	input  logic                result_stall,
	output logic signed [31:0]  min_value,
	output logic                status
);

	localparam int NODES = 4 * MAX_LENGTH;
	localparam int KW = $clog2(NODES);
	localparam int IW = $clog2(MAX_LENGTH);
	localparam int NW = $clog2(MAX_LENGTH + 1);
	localparam int CW = (NW > 11) ? NW : 11;
	localparam int SD = IW + 1;
	localparam int SPW = $clog2(SD + 1);
	localparam int IXW = $clog2(SD);

	typedef struct packed {
		logic [KW-1:0] k;
		logic [IW-1:0] lo;
		logic [IW-1:0] hi;
		logic          right;
		logic [31:0]   acc;
	} frame_t;

	logic [10:0]    len_q;
	logic [1:0]     op_q;
	logic [IW-1:0]  ql_q;
	logic [IW-1:0]  qh_q;
	logic [31:0]    v_q;
	logic           bad_q;
	frame_t         stk_q [SD];
	logic [SPW-1:0] sp_q;
	logic [31:0]    delta_q;
	logic [31:0]    val_q;
	logic [31:0]    ret_q;
	logic [31:0]    t1_q;
	logic [KW-1:0]  clr_q;
	logic           res_valid_q;
	logic [31:0]    res_min_q;
	logic           res_status_q;

	logic [CW-1:0]  len_ext, n, nm1, ql_ext, qh_ext, qh_cl;
	logic           bad_in;
	logic [SPW-1:0] spm1;
	logic [IXW-1:0] top_ix, push_ix;
	frame_t         top, child;
	logic [IW:0]    mid_sum;
	logic [IW-1:0]  mid;
	logic [KW-1:0]  c1, c2;
	logic           leaf, covered, disjoint, go_left;
	logic [31:0]    nm_rd, pa_rd, delta_c, nm_new, t2, rf_min, ret_min_v;
	logic [KW-1:0]  raddr, nm_wa, pa_wa;
	logic           nm_we, pa_we;
	logic [31:0]    nm_wd, pa_wd;

	assign len_ext = CW'(len_q);
	assign n = (len_ext == '0) ? CW'(1) :
		(len_ext > CW'(MAX_LENGTH)) ? CW'(MAX_LENGTH) : len_ext;
	assign nm1 = n - CW'(1);
	assign ql_ext = CW'(range_low);
	assign qh_ext = CW'(range_high);
	assign qh_cl = (qh_ext > nm1) ? nm1 : qh_ext;

	always_comb begin
		unique case (op)
			lrmt_pkg::OP_LOAD: bad_in = !(ql_ext < n);
			lrmt_pkg::OP_ADD, lrmt_pkg::OP_QUERY: bad_in = (ql_ext > qh_cl) || (ql_ext >= n);
			default: bad_in = 1'b1;
		endcase
	end

	assign spm1 = sp_q - SPW'(1);
	assign top_ix = spm1[IXW-1:0];
	assign push_ix = sp_q[IXW-1:0];
	assign top = stk_q[top_ix];
	assign mid_sum = {1'b0, top.lo} + {1'b0, top.hi};
	assign mid = mid_sum[IW:1];
	assign c1 = {top.k[KW-2:0], 1'b0} + KW'(1);
	assign c2 = {top.k[KW-2:0], 1'b0} + KW'(2);
	assign leaf = (top.lo == top.hi);
	assign covered = (top.lo >= ql_q) && (top.hi <= qh_q);
	assign disjoint = (top.hi < ql_q) || (top.lo > qh_q);
	assign go_left = (op_q != lrmt_pkg::OP_LOAD) || (ql_q <= mid);

	always_comb begin
		child = '0;
		child.k = go_left ? c1 : c2;
		child.lo = go_left ? top.lo : mid + IW'(1);
		child.hi = go_left ? mid : top.hi;
		if (cmd.go_right) begin
			child.k = c2;
			child.lo = mid + IW'(1);
			child.hi = top.hi;
		end
	end

	assign delta_c = pa_rd + (((op_q == lrmt_pkg::OP_ADD) && covered) ? v_q : 32'd0);
	assign nm_new = ((op_q == lrmt_pkg::OP_LOAD) && leaf) ? v_q : nm_rd + delta_c;
	assign t2 = nm_rd + pa_rd;
	assign rf_min = ($signed(t2) < $signed(t1_q)) ? t2 : t1_q;
	assign ret_min_v = ($signed(ret_q) < $signed(top.acc)) ? ret_q : top.acc;

	always_comb begin
		priority if (cmd.rd_node) begin
			raddr = top.k;
		end else if (cmd.visit || cmd.rf1) begin
			raddr = c1;
		end else if (cmd.ch1 || cmd.rf2) begin
			raddr = c2;
		end else begin
			raddr = top.k;
		end
	end

	assign nm_we = cmd.clr || cmd.visit || cmd.rf3;
	assign nm_wa = cmd.clr ? clr_q : top.k;
	assign nm_wd = cmd.clr ? lrmt_pkg::TOP_VALUE : (cmd.visit ? nm_new : rf_min);
	assign pa_we = cmd.clr || cmd.visit || cmd.ch1 || cmd.ch2;
	assign pa_wa = cmd.clr ? clr_q : (cmd.visit ? top.k : (cmd.ch1 ? c1 : c2));
	assign pa_wd = (cmd.clr || cmd.visit) ? 32'd0 : pa_rd + delta_q;

	lrmt_ram #(.WIDTH(32), .DEPTH(NODES)) u_node_ram (
		.clk  (clk),
		.we   (nm_we),
		.waddr(nm_wa),
		.wdata(nm_wd),
		.raddr(raddr),
		.rdata(nm_rd)
	);

	lrmt_ram #(.WIDTH(32), .DEPTH(NODES)) u_pend_ram (
		.clk  (clk),
		.we   (pa_we),
		.waddr(pa_wa),
		.wdata(pa_wd),
		.raddr(raddr),
		.rdata(pa_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= lrmt_pkg::LENGTH_RESET;
			sp_q <= '0;
			clr_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				len_q <= cfg_data;
			end
			if (cmd.clr) begin
				clr_q <= clr_q + KW'(1);
			end
			if (cmd.accept) begin
				sp_q <= SPW'(1);
			end else if (cmd.go_right || (cmd.next && !st.next_ret)) begin
				sp_q <= sp_q + SPW'(1);
			end else if (cmd.next || cmd.ret_min || cmd.rf3) begin
				sp_q <= spm1;
			end
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= op;
			ql_q <= ql_ext[IW-1:0];
			qh_q <= qh_cl[IW-1:0];
			v_q <= operand_value;
			bad_q <= bad_in;
			stk_q[0] <= '{k: '0, lo: '0, hi: nm1[IW-1:0], right: 1'b0, acc: 32'd0};
		end
		if (cmd.visit) begin
			delta_q <= delta_c;
			val_q <= nm_new;
		end
		if (cmd.rf2) begin
			t1_q <= t2;
		end
		if (cmd.next) begin
			if (st.next_ret) begin
				ret_q <= disjoint ? lrmt_pkg::TOP_VALUE : val_q;
			end else begin
				stk_q[top_ix].right <= (op_q == lrmt_pkg::OP_LOAD);
				stk_q[push_ix] <= child;
			end
		end
		if (cmd.go_right) begin
			stk_q[top_ix].acc <= ret_q;
			stk_q[top_ix].right <= 1'b1;
			stk_q[push_ix] <= child;
		end
		if (cmd.ret_min) begin
			ret_q <= ret_min_v;
		end
		if (cmd.out_load) begin
			res_status_q <= bad_q;
			if (op_q == lrmt_pkg::OP_QUERY) begin
				res_min_q <= bad_q ? lrmt_pkg::TOP_VALUE : ret_q;
			end else begin
				res_min_q <= 32'd0;
			end
		end
	end

	always_comb begin
		st.clr_done = (clr_q == KW'(NODES - 1));
		st.bad = bad_q;
		st.ch_push = !leaf && (delta_c != 32'd0);
		unique case (op_q)
			lrmt_pkg::OP_LOAD: st.next_ret = leaf;
			default: st.next_ret = covered || disjoint;
		endcase
		st.empty = (sp_q == '0);
		st.top_right = top.right;
		st.full = (sp_q == SPW'(SD));
		st.op = op_q;
		st.out_free = !res_valid_q || !result_stall;
	end

	assign result_valid = res_valid_q;
	assign min_value = res_min_q;
	assign status = res_status_q;

endmodule

// ===== design/lrmt_ctl.sv =====
// Controller state machine for the tree: clearing pass, node visits, returns and refreshes.
// Reads item_valid and the status bundle, drives item_stall and cmd. Depends on lrmt_pkg.
module lrmt_ctl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  lrmt_pkg::st_t  st,
	output lrmt_pkg::cmd_t cmd
);

	typedef enum logic [12:0] {
		S_CLEAR = 13'b0000000000001,
		S_IDLE  = 13'b0000000000010,
		S_CHK   = 13'b0000000000100,
		S_RD    = 13'b0000000001000,
		S_VISIT = 13'b0000000010000,
		S_CH1   = 13'b0000000100000,
		S_CH2   = 13'b0000001000000,
		S_NEXT  = 13'b0000010000000,
		S_RES   = 13'b0000100000000,
		S_RF1   = 13'b0001000000000,
		S_RF2   = 13'b0010000000000,
		S_RF3   = 13'b0100000000000,
		S_DONE  = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_stall = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (st.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (item_valid) begin
					cmd.accept = 1'b1;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				state_d = st.bad ? S_DONE : S_RD;
			end
			S_RD: begin
				cmd.rd_node = 1'b1;
				state_d = S_VISIT;
			end
			S_VISIT: begin
				cmd.visit = 1'b1;
				state_d = st.ch_push ? S_CH1 : S_NEXT;
			end
			S_CH1: begin
				cmd.ch1 = 1'b1;
				state_d = S_CH2;
			end
			S_CH2: begin
				cmd.ch2 = 1'b1;
				state_d = S_NEXT;
			end
			S_NEXT: begin
				cmd.next = 1'b1;
				state_d = st.next_ret ? S_RES : S_RD;
			end
			S_RES: begin
				if (st.empty) begin
					state_d = S_DONE;
				end else if (!st.top_right && st.op != lrmt_pkg::OP_LOAD) begin
					cmd.go_right = 1'b1;
					state_d = S_RD;
				end else if (st.op == lrmt_pkg::OP_QUERY) begin
					cmd.ret_min = 1'b1;
					state_d = S_RES;
				end else begin
					state_d = S_RF1;
				end
			end
			S_RF1: begin
				cmd.rf1 = 1'b1;
				state_d = S_RF2;
			end
			S_RF2: begin
				cmd.rf2 = 1'b1;
				state_d = S_RF3;
			end
			S_RF3: begin
				cmd.rf3 = 1'b1;
				state_d = S_RES;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

endmodule

// ===== design/lazy_range_add_min_tree_core.sv =====
// Top level of the lazy range-add / range-minimum tree over signed 32-bit elements.
// Joins the controller lrmt_ctl and the datapath lrmt_dp. Depends on lrmt_pkg.
//
// Items arrive on the item channel (item_valid/item_stall) with op, range_low,
// range_high and operand_value; a word is taken when item_valid is high and item_stall low.
// Every item gives one result word (min_value, status) on the result channel, held
// stable while result_stall is high. The result register lets the next item be
// taken while the previous result still waits.
// The element count is written through cfg_valid/cfg_ready/cfg_data; the user must
// write it only while idle, the block does not enforce this; cfg_ready is always high.
// One item is worked at a time. Each visited node costs a read (S_RD), a settle write
// (S_VISIT), an optional push of the pending addend into both children (S_CH1, S_CH2)
// and a decision step (S_NEXT). On the way back each inner node passes S_RES, which
// starts its right child for adds and queries, then folds in the child minimum for
// queries or runs the refresh S_RF1 to S_RF3 for loads and adds. A rejected item goes
// from the check straight to the result stage. All work is bounded by the single read
// and write port of each node store.
// After reset the node and pending stores are cleared one entry per cycle;
// item_stall stays high meanwhile.
module lazy_range_add_min_tree_core #(
	parameter int MAX_LENGTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [10:0]        cfg_data,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         op,
	input  logic [9:0]         range_low,
	input  logic [9:0]         range_high,
	input  logic signed [31:0] operand_value,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] min_value,
	output logic               status
);

	lrmt_pkg::cmd_t cmd;
	lrmt_pkg::st_t  st;

	assign cfg_ready = 1'b1;

	lrmt_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.st        (st),
		.cmd       (cmd)
	);

	lrmt_dp #(.MAX_LENGTH(MAX_LENGTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.op           (op),
		.range_low    (range_low),
		.range_high   (range_high),
		.operand_value(operand_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.min_value    (min_value),
		.status       (status)
	);

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |-> !cmd.clr)
		else $error("item accepted during the clearing pass");

	a_reject_value: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status) |-> (min_value == 32'sd0 || min_value == 32'sh7FFF_FFFF))
		else $error("rejected item carries a computed minimum");

	a_descend_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.next && !st.next_ret) |-> !st.full)
		else $error("traversal stack overflow on descend");

	a_right_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go_right |-> !st.full)
		else $error("traversal stack overflow on right child");

endmodule

// ===== tb/sv/lazy_range_add_min_tree_core_test.sv =====
// Self-checking testbench for lazy_range_add_min_tree_core: loads, range adds and range
// minimum queries under random bursts and stalls and several element counts, checked against a local tree.
// Depends on lrmt_pkg and the core RTL.
`timescale 1ns / 1ps

module lazy_range_add_min_tree_core_test;

	localparam int TREE_NODES = 4096;

	typedef struct packed {
		logic [1:0]  kind;
		logic [9:0]  lo_idx;
		logic [9:0]  hi_idx;
		logic [31:0] amount;
	} item_t;

	typedef struct packed {
		logic [31:0] minimum;
		logic        flag;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [10:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [1:0] op = '0;
	logic [9:0] range_low = '0;
	logic [9:0] range_high = '0;
	logic signed [31:0] operand_value = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [31:0] min_value;
	logic status;

	lazy_range_add_min_tree_core dut (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .item_valid(item_valid), .item_stall(item_stall), .op(op),
		.range_low(range_low), .range_high(range_high), .operand_value(operand_value),
		.result_valid(result_valid), .result_stall(result_stall), .min_value(min_value),
		.status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [31:0] tree_min [TREE_NODES];
	logic [31:0] tree_add [TREE_NODES];
	logic [10:0] element_count;
	item_t pending_items [$];
	answer_t expected_answers [$];
	int errors = 0;
	int answers_seen = 0;
	int cycles = 0;
	bit driver_hold = 1'b0;
	bit long_hold_request = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_left = 0;
	int long_hold_left = 0;

	function automatic logic [31:0] smin(logic [31:0] a, logic [31:0] b);
		return ($signed(b) < $signed(a)) ? b : a;
	endfunction

	function automatic logic [31:0] node_total(int k);
		if (k >= TREE_NODES) return lrmt_pkg::TOP_VALUE;
		return tree_min[k] + tree_add[k];
	endfunction

	function automatic void push_down(int k, int lo, int hi);
		logic [31:0] p;
		if (k >= TREE_NODES) return;
		p = tree_add[k];
		if (p == 0) return;
		tree_min[k] += p;
		tree_add[k] = 0;
		if (lo != hi) begin
			if (2 * k + 1 < TREE_NODES) tree_add[2 * k + 1] += p;
			if (2 * k + 2 < TREE_NODES) tree_add[2 * k + 2] += p;
		end
	endfunction

	function automatic void add_span(int ql, int qh, logic [31:0] d, int lo, int hi, int k);
		int mid;
		if (k >= TREE_NODES) return;
		push_down(k, lo, hi);
		if (hi < ql || lo > qh) return;
		if (lo >= ql && hi <= qh) begin
			tree_min[k] += d;
			if (lo != hi) begin
				if (2 * k + 1 < TREE_NODES) tree_add[2 * k + 1] += d;
				if (2 * k + 2 < TREE_NODES) tree_add[2 * k + 2] += d;
			end
			return;
		end
		mid = (lo + hi) / 2;
		add_span(ql, qh, d, lo, mid, 2 * k + 1);
		add_span(ql, qh, d, mid + 1, hi, 2 * k + 2);
		tree_min[k] = smin(node_total(2 * k + 1), node_total(2 * k + 2));
	endfunction

	function automatic logic [31:0] span_min(int ql, int qh, int lo, int hi, int k);
		int mid;
		if (k >= TREE_NODES) return lrmt_pkg::TOP_VALUE;
		push_down(k, lo, hi);
		if (lo >= ql && hi <= qh) return tree_min[k];
		if (hi < ql || lo > qh) return lrmt_pkg::TOP_VALUE;
		mid = (lo + hi) / 2;
		return smin(span_min(ql, qh, lo, mid, 2 * k + 1),
			span_min(ql, qh, mid + 1, hi, 2 * k + 2));
	endfunction

	function automatic void store_element(int pos, logic [31:0] v, int lo, int hi, int k);
		int mid;
		if (k >= TREE_NODES) return;
		push_down(k, lo, hi);
		if (lo == hi) begin
			tree_min[k] = v;
			return;
		end
		mid = (lo + hi) / 2;
		if (pos <= mid) store_element(pos, v, lo, mid, 2 * k + 1);
		else store_element(pos, v, mid + 1, hi, 2 * k + 2);
		tree_min[k] = smin(node_total(2 * k + 1), node_total(2 * k + 2));
	endfunction

	function automatic answer_t apply_item(item_t it);
		answer_t a;
		int n;
		int ql;
		int qh;
		n = element_count;
		if (n == 0) n = 1;
		if (n > 1024) n = 1024;
		ql = it.lo_idx;
		qh = it.hi_idx;
		a = '0;
		if (it.kind == lrmt_pkg::OP_LOAD) begin
			if (ql < n) store_element(ql, it.amount, 0, n - 1, 0);
			else a.flag = 1'b1;
		end else if (it.kind == lrmt_pkg::OP_ADD || it.kind == lrmt_pkg::OP_QUERY) begin
			if (qh > n - 1) qh = n - 1;
			if (ql > qh || ql >= n) begin
				a.flag = 1'b1;
				if (it.kind == lrmt_pkg::OP_QUERY) a.minimum = lrmt_pkg::TOP_VALUE;
			end else if (it.kind == lrmt_pkg::OP_ADD) begin
				add_span(ql, qh, it.amount, 0, n - 1, 0);
			end else begin
				a.minimum = span_min(ql, qh, 0, n - 1, 0);
			end
		end else begin
			a.flag = 1'b1;
		end
		return a;
	endfunction

	// Accepted words are predicted at the edge they are taken.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (item_valid && !item_stall)
			expected_answers.push_back(apply_item({op, range_low, range_high, operand_value}));
		if (result_valid && !result_stall) begin
			answers_seen <= answers_seen + 1;
			if (expected_answers.size() == 0) begin
				$display("%0t: unexpected result min_value=%0d status=%0d", $time,
					min_value, status);
				errors <= errors + 1;
			end else begin
				answer_t e;
				e = expected_answers.pop_front();
				if (e.minimum !== min_value || e.flag !== status) begin
					$display("%0t: mismatch expected min_value=%0d status=%0d, actual %0d %0d",
						$time, $signed(e.minimum), e.flag, min_value, status);
					errors <= errors + 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (item_valid && !item_stall) begin
			if (pending_items.size() > 0 && !driver_hold && gap_left == 0) begin
				item_t it;
				it = pending_items.pop_front();
				{op, range_low, range_high, operand_value} <= it;
				burst_left <= burst_left - 1;
				if (burst_left <= 1) gap_left <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
			end else begin
				item_valid <= 1'b0;
				if (burst_left <= 1) burst_left <= $urandom_range(1, 10);
			end
		end else if (!item_valid) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_items.size() > 0 && !driver_hold) begin
				item_t it;
				it = pending_items.pop_front();
				{op, range_low, range_high, operand_value} <= it;
				item_valid <= 1'b1;
				if (burst_left <= 0) burst_left <= $urandom_range(1, 10);
			end
		end
	end

	always @(posedge clk) begin
		if (long_hold_request && long_hold_left == 0) begin
			long_hold_left <= 3000;
			result_stall <= 1'b1;
		end else if (long_hold_left > 0) begin
			long_hold_left <= long_hold_left - 1;
			result_stall <= long_hold_left > 1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_stall <= 1'b1;
		end else if ($urandom_range(0, 9) < 2) begin
			stall_left <= $urandom_range(0, 20);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (cycles > 3000000) begin
			$display("lazy_range_add_min_tree_core_test: FAIL");
			$finish;
		end
	end

	function automatic int pick_index(int n);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return $urandom_range(0, 1023);
		if (r == 1) return n - 1;
		if (r == 2) return 0;
		return $urandom_range(0, n - 1);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 20) - 10;
			default: return $urandom();
		endcase
	endfunction

	task automatic queue_random(int count, int n);
		item_t it;
		int a;
		int b;
		repeat (count) begin
			a = pick_index(n);
			b = pick_index(n);
			if ($urandom_range(0, 5) != 0 && a > b) begin
				int t;
				t = a;
				a = b;
				b = t;
			end
			it.lo_idx = 10'(a);
			it.hi_idx = 10'(b);
			it.amount = pick_value();
			case ($urandom_range(0, 19))
				0: it.kind = 2'd3;
				1, 2, 3, 4, 5: it.kind = lrmt_pkg::OP_LOAD;
				6, 7, 8, 9, 10, 11: it.kind = lrmt_pkg::OP_ADD;
				default: it.kind = lrmt_pkg::OP_QUERY;
			endcase
			pending_items.push_back(it);
		end
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || item_valid || expected_answers.size() > 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_length(logic [10:0] value);
		@(posedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		element_count = value;
	endtask

	initial begin
		int lengths [5];
		for (int k = 0; k < TREE_NODES; k++) begin
			tree_min[k] = lrmt_pkg::TOP_VALUE;
			tree_add[k] = '0;
		end
		element_count = lrmt_pkg::LENGTH_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		pending_items.push_back({lrmt_pkg::OP_QUERY, 10'd0, 10'd1023, 32'd0});
		pending_items.push_back({lrmt_pkg::OP_LOAD, 10'd0, 10'd0, 32'h8000_0000});
		pending_items.push_back({lrmt_pkg::OP_LOAD, 10'd1023, 10'd1023, 32'h7FFF_FFFF});
		pending_items.push_back({lrmt_pkg::OP_LOAD, 10'd512, 10'h3FF, 32'd5});
		pending_items.push_back({lrmt_pkg::OP_ADD, 10'd0, 10'd1023, 32'h7FFF_FFFF});
		pending_items.push_back({lrmt_pkg::OP_QUERY, 10'd0, 10'd1023, 32'hFFFF_FFFF});
		pending_items.push_back({lrmt_pkg::OP_ADD, 10'd500, 10'd600, 32'h8000_0000});
		pending_items.push_back({lrmt_pkg::OP_QUERY, 10'd512, 10'd512, 32'd0});
		pending_items.push_back({lrmt_pkg::OP_QUERY, 10'd600, 10'd500, 32'd0});
		pending_items.push_back({lrmt_pkg::OP_ADD, 10'd9, 10'd3, 32'd1});
		pending_items.push_back({2'd3, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF});
		pending_items.push_back({lrmt_pkg::OP_QUERY, 10'd1023, 10'd1023, 32'd0});
		wait_drained();

		lengths = '{1, 1000, 2, 37, 1024};
		foreach (lengths[i]) begin
			write_length(11'(lengths[i]));
			if (lengths[i] == 1000) begin
				pending_items.push_back({lrmt_pkg::OP_LOAD, 10'd1001, 10'd0, 32'd1});
				pending_items.push_back({lrmt_pkg::OP_QUERY, 10'd999, 10'd1023, 32'd0});
				pending_items.push_back({lrmt_pkg::OP_ADD, 10'd1000, 10'd1023, 32'd1});
			end
			queue_random(i == 4 ? 250 : 150, lengths[i]);
			if (i == 2) begin
				long_hold_request = 1'b1;
				while (long_hold_left == 0) @(posedge clk);
				long_hold_request = 1'b0;
			end
			if (i == 3) begin
				driver_hold = 1'b1;
				while (expected_answers.size() > 0 || item_valid) @(posedge clk);
				driver_hold = 1'b0;
			end
			wait_drained();
		end
		write_length(11'd0);
		queue_random(20, 1);
		wait_drained();

		$display("Covered loads, range adds, queries, empty and out-of-range items and");
		$display("element counts from 1 to 1024, with %0d results checked.", answers_seen);
		if (errors == 0) begin
			$display("lazy_range_add_min_tree_core_test: PASS");
		end else begin
			$display("lazy_range_add_min_tree_core_test: FAIL");
		end
		$finish;
	end

endmodule
